// ----- rtl/soundex_word_encoder_macros.svh -----
// Assertion macros shared by the soundex encoder RTL.
// The clocked form is disabled during reset; the raw form also checks reset behavior.
`ifndef SOUNDEX_WORD_ENCODER_MACROS_SVH
`define SOUNDEX_WORD_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
`define SDX_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SDX_ASSERT_RAW(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SDX_ASSERT(label, prop, msg)
`define SDX_ASSERT_RAW(label, prop, msg)
`endif

`endif

// ----- rtl/sdx_pkg.sv -----
`default_nettype none

package sdx_pkg;

   localparam int NumDigits = 3;

   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5A;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerZ = 8'h7A;
   localparam logic [7:0] CaseBit    = 8'h20;

   typedef logic [2:0] digit_type;

   localparam digit_type DigitNone = 3'd0;
   localparam digit_type DigitLabial = 3'd1;
   localparam digit_type DigitSibilant = 3'd2;
   localparam digit_type DigitDental = 3'd3;
   localparam digit_type DigitLateral = 3'd4;
   localparam digit_type DigitNasal = 3'd5;
   localparam digit_type DigitRhotic = 3'd6;

   typedef struct packed {
      logic [7:0] in_char;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [6:0] code_letter;
      digit_type  digit_one;
      digit_type  digit_two;
      digit_type  digit_three;
      logic       has_code;
      logic       last_of_string;
   } rsp_type;

   // One request after classification, as held in the input register.
   typedef struct packed {
      logic       is_letter;
      logic [6:0] letter;
      digit_type  digit;
      logic       end_of_string;
   } char_type;

   // Soundex digit of an upper-case letter.
   function automatic digit_type letter_digit(input logic [7:0] upper);
      digit_type d;
      d = DigitNone;
      case (upper) inside
         "B", "F", "P", "V": d = DigitLabial;
         "C", "G", "J", "K", "Q", "S", "X", "Z": d = DigitSibilant;
         "D", "T": d = DigitDental;
         "L": d = DigitLateral;
         "M", "N": d = DigitNasal;
         "R": d = DigitRhotic;
         default: d = DigitNone;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/sdx_char_decode.sv -----
`default_nettype none

module sdx_char_decode (
   input  wire sdx_pkg::req_type  req,
   output sdx_pkg::char_type      dec
);

   logic       is_upper;
   logic       is_lower;
   logic [7:0] upper;

   assign is_upper = (req.in_char >= sdx_pkg::CharUpperA) && (req.in_char <= sdx_pkg::CharUpperZ);
   assign is_lower = (req.in_char >= sdx_pkg::CharLowerA) && (req.in_char <= sdx_pkg::CharLowerZ);
   assign upper    = req.in_char & ~sdx_pkg::CaseBit;

   always_comb begin
      dec.is_letter     = is_upper || is_lower;
      dec.letter        = upper[6:0];
      dec.digit         = dec.is_letter ? sdx_pkg::letter_digit(upper) : sdx_pkg::DigitNone;
      dec.end_of_string = req.end_of_string;
   end

endmodule

`default_nettype wire

// ----- rtl/soundex_word_encoder.sv -----
// Soundex word encoder: takes one byte of a string per cycle unless stalled and returns
// one code per run of ASCII letters (upper-case first letter and three digits, zero
// padded), plus a result at every end-of-string byte (a bare end marker with has_code
// low when no word is open). A request is classified into the input register, then the
// word-state update fills the result register, so the block sustains one byte per clock
// while the result side does not stall. The rate is set by the single word-state register
// update, which carries the open word from one byte to the next.
`default_nettype none
`include "soundex_word_encoder_macros.svh"

module soundex_word_encoder (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire sdx_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output sdx_pkg::rsp_type       rsp_data
);

   sdx_pkg::char_type  dec;
   sdx_pkg::char_type  char_ff;
   logic               in_valid_ff;
   logic               in_valid_in;
   logic               advance;

   logic               word_active_ff, word_active_in;
   logic [6:0]         first_letter_ff, first_letter_in;
   sdx_pkg::digit_type last_code_ff, last_code_in;
   logic [1:0]         digit_count_ff, digit_count_in;
   sdx_pkg::digit_type digit_ff [sdx_pkg::NumDigits];
   sdx_pkg::digit_type digit_in [sdx_pkg::NumDigits];

   logic               emit;
   sdx_pkg::rsp_type   rsp_in;
   sdx_pkg::rsp_type   rsp_data_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   sdx_char_decode u_decode (
      .req (req_data),
      .dec (dec)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Word-state update for the byte held in the input register.
   always_comb begin
      word_active_in  = word_active_ff;
      first_letter_in = first_letter_ff;
      last_code_in    = last_code_ff;
      digit_count_in  = digit_count_ff;
      digit_in        = digit_ff;

      if (char_ff.is_letter) begin
         if (!word_active_ff) begin
            word_active_in  = 1'b1;
            first_letter_in = char_ff.letter;
            last_code_in    = char_ff.digit;
            digit_count_in  = 2'd0;
            digit_in        = '{default: sdx_pkg::DigitNone};
         end else if (char_ff.digit != sdx_pkg::DigitNone && char_ff.digit != last_code_ff
                      && digit_count_ff < 2'(sdx_pkg::NumDigits)) begin
            digit_in[digit_count_ff] = char_ff.digit;
            digit_count_in           = digit_count_ff + 2'd1;
            last_code_in             = char_ff.digit;
         end
      end

      emit = char_ff.end_of_string || (!char_ff.is_letter && word_active_ff);

      rsp_in.has_code       = word_active_in;
      rsp_in.code_letter    = word_active_in ? first_letter_in : 7'd0;
      rsp_in.digit_one      = word_active_in ? digit_in[0] : sdx_pkg::DigitNone;
      rsp_in.digit_two      = word_active_in ? digit_in[1] : sdx_pkg::DigitNone;
      rsp_in.digit_three    = word_active_in ? digit_in[2] : sdx_pkg::DigitNone;
      rsp_in.last_of_string = char_ff.end_of_string;

      // A finished word leaves the state clear for the next one.
      if (emit) begin
         word_active_in  = 1'b0;
         first_letter_in = 7'd0;
         last_code_in    = sdx_pkg::DigitNone;
         digit_count_in  = 2'd0;
         digit_in        = '{default: sdx_pkg::DigitNone};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         word_active_ff  <= 1'b0;
         first_letter_ff <= 7'd0;
         last_code_ff    <= sdx_pkg::DigitNone;
         digit_count_ff  <= 2'd0;
         digit_ff        <= '{default: sdx_pkg::DigitNone};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            word_active_ff  <= word_active_in;
            first_letter_ff <= first_letter_in;
            last_code_ff    <= last_code_in;
            digit_count_ff  <= digit_count_in;
            digit_ff        <= digit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff <= dec;
      end
      if (advance && emit) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SDX_ASSERT_RAW(a_reset_empties, reset |=> !in_valid_ff && !rsp_valid_ff && !word_active_ff, "reset left a request or word in flight")
   `SDX_ASSERT(a_count_needs_word, digit_count_ff != 2'd0 |-> word_active_ff, "digits stored with no open word")
   `SDX_ASSERT(a_eos_closes_word, advance && char_ff.end_of_string |=> !word_active_ff, "word still open after end of string")
   `SDX_ASSERT(a_digits_in_order, digit_count_ff < 2'd2 |-> digit_ff[1] == sdx_pkg::DigitNone && digit_ff[2] == sdx_pkg::DigitNone, "digit stored beyond the count")
   `SDX_ASSERT(a_code_has_letter, rsp_valid_ff && rsp_data_ff.has_code |-> rsp_data_ff.code_letter != 7'd0, "word code without a first letter")

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int CycleLimit   = 200000;
   localparam int HoldCycles   = 250;
   localparam int DrainCycles  = 8;
   localparam int RandomItems  = 340;
   localparam int QuietItems   = 80;
   localparam int PressureItems = 60;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   sdx_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   sdx_pkg::rsp_type rsp_data;

   soundex_word_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Predictor state for the word being built.
   bit                 word_open;
   logic [6:0]         lead_letter;
   sdx_pkg::digit_type prev_digit;
   int                 stored_digits;
   sdx_pkg::digit_type digit_slots [0:2];

   sdx_pkg::rsp_type   expected_codes [$];
   int                 error_count;
   int                 chars_sent;
   int                 codes_checked;
   int                 markers_checked;
   int                 cycle_count;
   bit                 no_idle;
   logic               rsp_hold_request;
   int                 hold_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit is_letter(input logic [7:0] ch);
      return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
   endfunction

   function automatic sdx_pkg::digit_type sound_class(input logic [7:0] up);
      case (up)
         "B", "F", "P", "V": return sdx_pkg::DigitLabial;
         "C", "G", "J", "K", "Q", "S", "X", "Z": return sdx_pkg::DigitSibilant;
         "D", "T": return sdx_pkg::DigitDental;
         "L": return sdx_pkg::DigitLateral;
         "M", "N": return sdx_pkg::DigitNasal;
         "R": return sdx_pkg::DigitRhotic;
         default: return sdx_pkg::DigitNone;
      endcase
   endfunction

   function automatic void clear_word();
      word_open = 1'b0;
      lead_letter = '0;
      prev_digit = sdx_pkg::DigitNone;
      stored_digits = 0;
      for (int i = 0; i < 3; i++) digit_slots[i] = sdx_pkg::DigitNone;
   endfunction

   // Advances the word state by one request; returns 1 when a code is due.
   function automatic bit soundex_next(input sdx_pkg::req_type r,
                                       output sdx_pkg::rsp_type code);
      logic [7:0]         ch;
      logic [7:0]         up;
      bit                 letter;
      sdx_pkg::digit_type d;
      ch = r.in_char;
      letter = is_letter(ch);
      up = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
      code = '0;
      if (letter) begin
         d = sound_class(up);
         if (!word_open) begin
            clear_word();
            word_open = 1'b1;
            lead_letter = up[6:0];
            prev_digit = d;
         end else if (d != sdx_pkg::DigitNone && d != prev_digit && stored_digits < 3) begin
            digit_slots[stored_digits] = d;
            stored_digits++;
            prev_digit = d;
         end
      end
      if (r.end_of_string || (!letter && word_open)) begin
         if (word_open) begin
            code.code_letter = lead_letter;
            code.digit_one = digit_slots[0];
            code.digit_two = digit_slots[1];
            code.digit_three = digit_slots[2];
            code.has_code = 1'b1;
         end
         code.last_of_string = r.end_of_string;
         clear_word();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic report_field(input string field, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   // Checks each accepted result first, then predicts from the request taken at the same
   // edge; a request cannot produce its result at the edge that accepts it.
   always @(posedge clock) begin
      sdx_pkg::rsp_type want;
      sdx_pkg::rsp_type code;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_codes.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
               error_count++;
            end else begin
               want = expected_codes.pop_front();
               report_field("code_letter", want.code_letter, rsp_data.code_letter);
               report_field("digit_one", want.digit_one, rsp_data.digit_one);
               report_field("digit_two", want.digit_two, rsp_data.digit_two);
               report_field("digit_three", want.digit_three, rsp_data.digit_three);
               report_field("has_code", want.has_code, rsp_data.has_code);
               report_field("last_of_string", want.last_of_string, rsp_data.last_of_string);
               if (want.has_code) codes_checked++;
               else markers_checked++;
            end
         end
         if (req_valid && req_ready) begin
            if (soundex_next(req_data, code)) expected_codes.push_back(code);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_codes.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off on demand.
   initial begin
      rsp_ready <= 1'b0;
      rsp_hold_request <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request <= 1'b0;
            rsp_ready <= 1'b0;
            for (hold_count = 0; hold_count < HoldCycles; hold_count++) @(posedge clock);
         end
         rsp_ready <= no_idle || ($urandom_range(99) >= 29);
      end
   end

   task automatic send_char(input logic [7:0] ch, input logic eos);
      sdx_pkg::req_type r;
      while (!no_idle && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      r.in_char = ch;
      r.end_of_string = eos;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_text(input string s, input bit eos_on_last);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], eos_on_last && (i == s.len() - 1));
   endtask

   function automatic logic [7:0] random_letter();
      logic [7:0] base;
      base = $urandom_range(1) ? "a" : "A";
      return base + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] random_separator();
      logic [7:0] ch;
      ch = 8'($urandom_range(255));
      while (is_letter(ch)) ch = 8'($urandom_range(255));
      return ch;
   endfunction

   // Mostly words of random letters and case, with the rest raw bytes.
   task automatic send_random_stream(input int count);
      int  stop_at;
      int  len;
      bit  ended;
      stop_at = chars_sent + count;
      while (chars_sent < stop_at) begin
         if ($urandom_range(99) < 80) begin
            len = $urandom_range(9, 1);
            ended = 1'b0;
            for (int i = 0; i < len; i++) begin
               ended = (i == len - 1) && ($urandom_range(99) < 15);
               send_char(random_letter(), ended);
            end
            if (!ended) send_char(random_separator(), $urandom_range(9) == 0);
         end else begin
            send_char(8'($urandom_range(255)), $urandom_range(9) == 0);
         end
      end
   endtask

   task automatic test_directed();
      send_char(8'h00, 1'b0);
      send_text("Robert ", 1'b0);
      // A leading 'u' must not swallow the first digit.
      send_text("Uber", 1'b1);
      // A one-letter word closed by the end of the string.
      send_text("Z", 1'b1);
      // End of string with no open word gives a bare end marker.
      send_char(8'hFF, 1'b1);
      send_text("aL@", 1'b0);
      send_text("mm[", 1'b0);
      send_text("`{", 1'b0);
      send_char("z", 1'b0);
      send_char(8'h80, 1'b1);
   endtask

   task automatic test_random_text();
      send_random_stream(RandomItems);
   endtask

   task automatic test_full_rate();
      no_idle = 1'b1;
      send_random_stream(QuietItems);
      no_idle = 1'b0;
   endtask

   task automatic test_backpressure();
      no_idle = 1'b1;
      rsp_hold_request <= 1'b1;
      send_random_stream(PressureItems);
      no_idle = 1'b0;
   endtask

   initial begin
      clear_word();
      error_count = 0;
      chars_sent = 0;
      codes_checked = 0;
      markers_checked = 0;
      cycle_count = 0;
      no_idle = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_text();
      test_full_rate();
      test_backpressure();

      req_valid <= 1'b0;
      // Let the checker record the last request before looking at the queue.
      repeat (2) @(posedge clock);
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (expected_codes.size() != 0) begin
         $display("%0t: results missing, expected 0 outstanding, actual %0d",
                  $time, expected_codes.size());
         error_count++;
      end

      $display("Sent %0d characters; checked %0d word codes and %0d bare end markers,",
               chars_sent, codes_checked, markers_checked);
      $display("with random stalls, a full-rate stretch and one long result hold-off.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
